// ===== hdl/ics_pkg.sv =====
// Shared types and constants for the internet checksum core.
// Depends on nothing; used by ics_cfg_regs and internet_checksum_pseudo_header_core.
`timescale 1ns / 1ps

package ics_pkg;

	localparam int WORD_W   = 16;
	localparam int ADDR_W   = 32;
	localparam int PSEUDO_W = 19;
	localparam int TOTAL_W  = 19;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_ADDR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_ADDR = 2'd2;

	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_UDP   = 2'd1;
	localparam logic [1:0] MODE_TCP   = 2'd2;

	localparam logic [WORD_W-1:0] PROTO_UDP = 16'h0011;
	localparam logic [WORD_W-1:0] PROTO_TCP = 16'h0006;

	localparam logic [WORD_W-1:0] UPPER_BYTE_MASK = 16'hFF00;

	typedef struct packed {
		logic [WORD_W-1:0] data_word;
		logic              single_byte;
		logic              last;
	} in_t;

	typedef struct packed {
		logic [WORD_W-1:0] checksum;
		logic [WORD_W-1:0] byte_length;
	} out_t;

	typedef struct packed {
		logic                pseudo_en;
		logic [PSEUDO_W-1:0] pseudo_sum;
	} hdr_cfg_t;

endpackage

// ===== hdl/internet_checksum_pseudo_header_core.sv =====
// Top level: streaming RFC 1071 checksum with optional UDP/TCP pseudo-header.
// Depends on ics_pkg and ics_cfg_regs.
//
//   channel | handshake              | payload
//   in      | in_valid / in_ready    | in_data  (ics_pkg::in_t)
//   out     | out_valid / out_ready  | out_data (ics_pkg::out_t)
//   cfg     | cfg_we                 | cfg_index, cfg_data
//
// One word is taken per cycle while in_ready is high. A result passes from the
// transfer of the last word through the input register, sum stage and fold
// stage to the output register. Reset clears the running sum, byte count, valid flags and
// configuration registers. A stalled result holds the output register; one
// more result can wait in the sum stage, and non-last words keep flowing
// until a further last word waits in the input register.
`timescale 1ns / 1ps

module internet_checksum_pseudo_header_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ics_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ics_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [ics_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ics_pkg::ADDR_W-1:0]    cfg_data
);

	ics_pkg::hdr_cfg_t hdr_cfg;

	logic                         v_s1;
	logic [ics_pkg::WORD_W-1:0]   word_s1;
	logic                         half_s1;
	logic                         last_s1;
	logic [ics_pkg::WORD_W-1:0]   sum_q;
	logic [ics_pkg::WORD_W-1:0]   cnt_q;
	logic                         v_s2;
	logic [ics_pkg::WORD_W-1:0]   sum_s2;
	logic [ics_pkg::WORD_W-1:0]   cnt_s2;
	logic                         out_v_q;
	ics_pkg::out_t                out_q;

	logic                         out_free;
	logic                         s2_free;
	logic                         s1_move;
	logic [ics_pkg::WORD_W:0]     sum_wide;
	logic [ics_pkg::WORD_W-1:0]   sum_next;
	logic [ics_pkg::WORD_W-1:0]   cnt_next;
	logic [ics_pkg::TOTAL_W-1:0]  total;
	logic [ics_pkg::WORD_W:0]     fold1;
	logic [ics_pkg::WORD_W-1:0]   fold2;

	ics_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.hdr_cfg   (hdr_cfg)
	);

	assign out_free = !out_v_q || out_ready;
	assign s2_free  = !v_s2 || out_free;
	assign s1_move  = v_s1 && (!last_s1 || s2_free);
	assign in_ready = !v_s1 || s1_move;

	always_comb begin
		sum_wide = {1'b0, sum_q} + {1'b0, word_s1};
		sum_next = sum_wide[ics_pkg::WORD_W-1:0] + {{(ics_pkg::WORD_W-1){1'b0}}, sum_wide[ics_pkg::WORD_W]};
		cnt_next = cnt_q + {{(ics_pkg::WORD_W-2){1'b0}}, !half_s1, half_s1};
	end

	always_comb begin
		total = {3'b000, sum_s2} + hdr_cfg.pseudo_sum
			+ (hdr_cfg.pseudo_en ? {3'b000, cnt_s2} : '0);
		fold1 = {1'b0, total[ics_pkg::WORD_W-1:0]}
			+ {14'd0, total[ics_pkg::TOTAL_W-1:ics_pkg::WORD_W]};
		fold2 = fold1[ics_pkg::WORD_W-1:0] + {{(ics_pkg::WORD_W-1){1'b0}}, fold1[ics_pkg::WORD_W]};
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_data.single_byte ?
				(in_data.data_word & ics_pkg::UPPER_BYTE_MASK) : in_data.data_word;
			half_s1 <= in_data.single_byte;
			last_s1 <= in_data.last;
		end
	end

	// running sum and byte count; clear after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (s1_move) begin
			if (last_s1) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= s1_move && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && last_s1) begin
			sum_s2 <= sum_next;
			cnt_s2 <= cnt_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && out_free) begin
			out_q.checksum    <= ~fold2;
			out_q.byte_length <= cnt_s2;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

// ===== hdl/ics_cfg_regs.sv =====
// Configuration registers and pseudo-header partial sum.
// Depends on ics_pkg.
`timescale 1ns / 1ps

module ics_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ics_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ics_pkg::ADDR_W-1:0]        cfg_data,
	output ics_pkg::hdr_cfg_t                 hdr_cfg
);

	logic [1:0]                   mode_q;
	logic [ics_pkg::ADDR_W-1:0]   src_q;
	logic [ics_pkg::ADDR_W-1:0]   dst_q;
	logic                         en_q;
	logic [ics_pkg::PSEUDO_W-1:0] pseudo_q;
	logic                         en_d;
	logic [ics_pkg::WORD_W-1:0]   proto_d;
	logic [ics_pkg::PSEUDO_W-1:0] pseudo_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ics_pkg::MODE_PLAIN;
			src_q  <= '0;
			dst_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ics_pkg::REG_MODE:     mode_q <= cfg_data[1:0];
				ics_pkg::REG_SRC_ADDR: src_q  <= cfg_data;
				ics_pkg::REG_DST_ADDR: dst_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (mode_q)
			ics_pkg::MODE_UDP: begin
				en_d    = 1'b1;
				proto_d = ics_pkg::PROTO_UDP;
			end
			ics_pkg::MODE_TCP: begin
				en_d    = 1'b1;
				proto_d = ics_pkg::PROTO_TCP;
			end
			default: begin
				en_d    = 1'b0;
				proto_d = '0;
			end
		endcase
		pseudo_d = {3'b000, src_q[31:16]} + {3'b000, src_q[15:0]}
			+ {3'b000, dst_q[31:16]} + {3'b000, dst_q[15:0]} + {3'b000, proto_d};
	end

	// precompute once per cycle; the user must keep config static while items flow, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			pseudo_q <= '0;
		end else begin
			en_q     <= en_d;
			pseudo_q <= en_d ? pseudo_d : '0;
		end
	end

	assign hdr_cfg.pseudo_en  = en_q;
	assign hdr_cfg.pseudo_sum = pseudo_q;

endmodule

// ===== dv/ics_result_checker.sv =====
// Checker for the internet checksum core: watches the config port and both channels,
// predicts each checksum and byte length, and compares them with the output transfers.
// Depends on ics_pkg.
`timescale 1ns / 1ps

module ics_result_checker
	import ics_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_t                  in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	output int                   outstanding,
	output int                   fail_count
);

	logic [1:0]        mode_q;
	logic [ADDR_W-1:0] src_q;
	logic [ADDR_W-1:0] dst_q;
	logic [WORD_W-1:0] run_sum;
	logic [WORD_W-1:0] byte_cnt;
	out_t              checksum_q[$];
	int                mismatches;

	function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
	endfunction

	task automatic accumulate_word(input in_t item);
		logic [WORD_W-1:0] word;
		logic [WORD_W-1:0] acc;
		out_t              res;
		word = item.single_byte ? (item.data_word & UPPER_BYTE_MASK) : item.data_word;
		byte_cnt = byte_cnt + (item.single_byte ? 16'd1 : 16'd2);
		run_sum = ones_add(run_sum, word);
		if (item.last) begin
			acc = run_sum;
			if (mode_q == MODE_UDP || mode_q == MODE_TCP) begin
				acc = ones_add(acc, src_q[31:16]);
				acc = ones_add(acc, src_q[15:0]);
				acc = ones_add(acc, dst_q[31:16]);
				acc = ones_add(acc, dst_q[15:0]);
				acc = ones_add(acc, (mode_q == MODE_UDP) ? PROTO_UDP : PROTO_TCP);
				acc = ones_add(acc, byte_cnt);
			end
			res.checksum = ~acc;
			res.byte_length = byte_cnt;
			checksum_q.push_back(res);
			run_sum = '0;
			byte_cnt = '0;
		end
	endtask

	task automatic check_result(input out_t got);
		out_t exp;
		if (checksum_q.size() == 0) begin
			$display("%0t: unexpected result, expected none, got checksum %h length %h",
				$time, got.checksum, got.byte_length);
			mismatches++;
		end else begin
			exp = checksum_q.pop_front();
			if (got.checksum !== exp.checksum) begin
				$display("%0t: checksum mismatch, expected %h, got %h",
					$time, exp.checksum, got.checksum);
				mismatches++;
			end
			if (got.byte_length !== exp.byte_length) begin
				$display("%0t: byte_length mismatch, expected %h, got %h",
					$time, exp.byte_length, got.byte_length);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = MODE_PLAIN;
			src_q = '0;
			dst_q = '0;
			run_sum = '0;
			byte_cnt = '0;
			checksum_q.delete();
			mismatches = 0;
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: mode_q = cfg_data[1:0];
					REG_SRC_ADDR: src_q = cfg_data;
					REG_DST_ADDR: dst_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				accumulate_word(in_data);
			if (out_valid && out_ready)
				check_result(out_data);
			outstanding <= checksum_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

// ===== dv/tb_internet_checksum_pseudo_header_core.sv =====
// Testbench top for internet_checksum_pseudo_header_core: drives words, config writes
// and output back-pressure; ics_result_checker predicts and compares. Depends on ics_pkg.
`timescale 1ns / 1ps

module tb_internet_checksum_pseudo_header_core;
	import ics_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
	localparam logic [1:0]           MODE_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_data = '0;
	int                   outstanding;
	int                   fail_count;
	int                   send_idle_pct = 0;
	int                   recv_stall_pct = 0;

	internet_checksum_pseudo_header_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ics_result_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200_000;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic in_t word_item(input logic [WORD_W-1:0] w, input logic single,
			input logic last_word);
		in_t it;
		it.data_word = w;
		it.single_byte = single;
		it.last = last_word;
		return it;
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	task automatic send_item(input in_t item);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_message(input int words, input logic odd_end);
		for (int i = 0; i < words; i++) begin
			if (i == words - 1)
				send_item(word_item(pick_word(), odd_end, 1'b1));
			else
				send_item(word_item(pick_word(), ($urandom_range(9) == 0), 1'b0));
		end
	endtask

	// hold off until every result is out and the pipeline is empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_settings(input logic [1:0] mode, input logic [ADDR_W-1:0] src,
			input logic [ADDR_W-1:0] dst);
		logic [ADDR_W-1:0] junk;
		junk = $urandom();
		cfg_we <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_data <= {junk[ADDR_W-1:2], mode};
		@(posedge clk);
		cfg_index <= REG_SRC_ADDR;
		cfg_data <= src;
		@(posedge clk);
		cfg_index <= REG_DST_ADDR;
		cfg_data <= dst;
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_data <= $urandom();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int sent;
		bit paused;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: plain sum
		send_item(word_item(16'h0000, 1'b0, 1'b1));
		send_item(word_item(16'hFFFF, 1'b0, 1'b1));
		send_item(word_item(16'hFFFF, 1'b0, 1'b0));
		send_item(word_item(16'h0001, 1'b0, 1'b1));
		send_item(word_item(16'hABCD, 1'b1, 1'b0));
		send_item(word_item(16'h1234, 1'b0, 1'b1));
		send_item(word_item(16'h12FF, 1'b1, 1'b1));
		drain();

		write_settings(MODE_UDP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(word_item(16'h0000, 1'b0, 1'b1));
		send_item(word_item(16'hFFFF, 1'b0, 1'b0));
		send_item(word_item(16'h00AA, 1'b1, 1'b1));
		drain();

		write_settings(MODE_TCP, 32'h0000_0000, 32'h0000_0000);
		send_item(word_item(16'hFFFF, 1'b0, 1'b1));
		send_item(word_item(16'h1234, 1'b0, 1'b0));
		send_item(word_item(16'h5678, 1'b1, 1'b1));
		drain();

		write_settings(MODE_UNUSED, $urandom(), $urandom());
		send_item(word_item(16'h8000, 1'b0, 1'b0));
		send_item(word_item(16'h8000, 1'b0, 1'b1));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					write_settings(MODE_TCP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				end
				1: begin
					send_idle_pct = 80;
					recv_stall_pct = 0;
					write_settings(MODE_UDP, 32'h0000_0000, 32'h0000_0000);
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 80;
					write_settings(MODE_UNUSED, $urandom(), $urandom());
				end
				default: begin
					send_idle_pct = 36;
					recv_stall_pct = 36;
					write_settings(MODE_PLAIN, $urandom(), $urandom());
				end
			endcase
			sent = 0;
			paused = 0;
			while (sent < 32) begin
				if ($urandom_range(19) == 0)
					send_message($urandom_range(20, 64), 1'($urandom_range(1)));
				else
					send_message($urandom_range(1, 10), 1'($urandom_range(1)));
				sent += 1;
				if (!paused && sent >= 16) begin
					drain();
					paused = 1;
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
